// ===== rtl/spcg_pkg.sv =====
// Shared constants and types for the stereo pan, crossfeed and gain chain.
`timescale 1ns / 1ps
package spcg_pkg;
	localparam int SAMPLE_W = 16;
	localparam int STATE_W  = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAN     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd2;
	localparam logic [15:0] COEF_DIRECT = 16'd9830;
	localparam logic [15:0] COEF_LP_IN  = 16'd17367;
	localparam logic [15:0] COEF_LP_FB  = 16'd15401;
	localparam logic [15:0] COEF_CROSS  = 16'd26214;
	localparam int MUL_W = 40;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PAN,
		ST_AP_NODE,
		ST_AP_OUT,
		ST_LP_IN,
		ST_LP_FB,
		ST_CROSS,
		ST_GAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                start;
		logic signed [39:0]  a;
		logic        [16:0]  b;
	} mul_req_t;

	typedef struct packed {
		logic                done;
		logic signed [MUL_W+17:0] p;
	} mul_rsp_t;
endpackage

// ===== rtl/spcg_if.sv =====
// Valid/ready channel interfaces for frames and configuration writes.
`timescale 1ns / 1ps
interface spcg_frame_if;
	logic        valid;
	logic        ready;
	logic [15:0] left;
	logic [15:0] right;
	logic        last;
	modport source (output valid, left, right, last, input ready);
	modport sink (input valid, left, right, last, output ready);
endinterface

interface spcg_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/stereo_pan_crossfeed_gain_chain_core.sv =====
// Top level of the stereo pan, crossfeed and gain chain.
// Usage:
//  in  : frame requests (left, right, last) on a valid/ready channel.
//  out : processed frames on a valid/ready channel, one per request.
//  cfg : register writes (0 enables, 1 pan, 2 gain) taken at any time;
//        write only while no frame is in flight.
// One frame is in work at a time. Every multiply goes through one bit-serial
// multiplier. Pan takes 2 products, crossfeed 10, gain 2: up to 14 products
// per frame with all stages on; with the allow bit clear the frame goes
// straight to done without a product.
// The result waits in an output register; while it waits the next request
// is not taken until the result is drained. A new request is taken the cycle
// after the result is accepted.
// Reset clears the delay lines, lowpass state and ring position and loads the register defaults.
// A stalled receiver holds the result and the input stays not ready.
`timescale 1ns / 1ps
module stereo_pan_crossfeed_gain_chain_core import spcg_pkg::*; #(
	parameter int DELAY_TAPS = 22
) (
	input  logic clk,
	input  logic arst_n,
	spcg_frame_if.sink   in,
	spcg_frame_if.source out,
	spcg_cfg_if.sink     cfg
);
	logic [3:0]  en_q;
	logic [8:0]  pan_q;
	logic [15:0] gain_q;
	logic        busy, done, start, ovalid_q, olast_q, last_q;
	logic [15:0] lres, rres, oleft_q, oright_q;
	mul_req_t mreq;
	mul_rsp_t mrsp;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 4'd1;
			pan_q  <= 9'd89;
			gain_q <= 16'd256;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ENABLES: en_q   <= cfg.data[3:0];
				REG_PAN:     pan_q  <= cfg.data[8:0];
				REG_GAIN:    gain_q <= cfg.data;
				default:     en_q   <= en_q;
			endcase
		end
	end

	assign in.ready = !busy && !ovalid_q;
	assign start = in.valid && in.ready;

	spcg_seq #(.DELAY_TAPS(DELAY_TAPS)) u_seq (
		.clk, .arst_n, .start, .l_in(in.left), .r_in(in.right),
		.enables(en_q), .pan(pan_q), .gain(gain_q),
		.busy, .done, .l_res(lres), .r_res(rres), .mreq, .mrsp
	);

	spcg_serial_mul u_mul (.clk, .arst_n, .req(mreq), .rsp(mrsp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (done) ovalid_q <= 1'b1;
		else if (out.ready) ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (start) last_q <= in.last;
		if (done) begin
			oleft_q  <= lres;
			oright_q <= rres;
			olast_q  <= last_q;
		end
	end

	assign out.valid = ovalid_q;
	assign out.left  = oleft_q;
	assign out.right = oright_q;
	assign out.last  = olast_q;

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in.ready) else $error("request taken while busy");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !out.ready |=> ovalid_q && $stable(oleft_q))
		else $error("result dropped");
endmodule

// ===== rtl/spcg_serial_mul.sv =====
// Bit-serial signed by unsigned multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module spcg_serial_mul import spcg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);
	localparam int PW = MUL_W + 18;
	logic signed [PW-1:0] acc_q;
	logic signed [PW-1:0] mcand_q;
	logic [16:0] mplier_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				done_q <= 1'b0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd16) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q    <= '0;
			mcand_q  <= PW'(req.a);
			mplier_q <= req.b;
		end else if (busy_q) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = acc_q;
endmodule

// ===== rtl/spcg_seq.sv =====
// Sequencer for pan, allpass, lowpass, crossfeed and gain on one frame.
`timescale 1ns / 1ps
module spcg_seq import spcg_pkg::*; #(
	parameter int DELAY_TAPS = 22
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] l_in,
	input  logic [15:0] r_in,
	input  logic [3:0]  enables,
	input  logic [8:0]  pan,
	input  logic [15:0] gain,
	output logic        busy,
	output logic        done,
	output logic [15:0] l_res,
	output logic [15:0] r_res,
	output mul_req_t    mreq,
	input  mul_rsp_t    mrsp
);
	localparam int PW = $clog2(DELAY_TAPS) > 0 ? $clog2(DELAY_TAPS) : 1;
	localparam int P = MUL_W + 18;
	localparam logic signed [P-1:0] Q24MAX = P'(8388607);
	localparam logic signed [P-1:0] Q24MIN = -P'(8388608);
	localparam logic signed [P-1:0] S16MAX = P'(32767);
	localparam logic signed [P-1:0] S16MIN = -P'(32768);

	state_t state_q, state_d;
	logic ch_q;
	logic issued_q;
	logic [PW-1:0] pos_q;
	logic signed [STATE_W-1:0] dl_l_q [DELAY_TAPS];
	logic signed [STATE_W-1:0] dl_r_q [DELAY_TAPS];
	logic signed [STATE_W-1:0] lp_q [2];
	logic signed [STATE_W-1:0] head_q, node_q, apo_q;
	logic signed [STATE_W-1:0] filt_q [2];
	logic signed [P-1:0] tmp_q;
	logic signed [SAMPLE_W-1:0] smp_q [2];
	logic signed [SAMPLE_W-1:0] pre_q [2];
	logic signed [P-1:0] p_fl, own, sum, q128, node_d, lp_y;
	logic last_ch;

	function automatic logic signed [P-1:0] sat(logic signed [P-1:0] x,
		logic signed [P-1:0] lo, logic signed [P-1:0] hi);
		return x > hi ? hi : (x < lo ? lo : x);
	endfunction

	assign p_fl = mrsp.p >>> 15;
	assign last_ch = ch_q;
	assign node_d = sat((P'(smp_q[ch_q]) <<< 6) - p_fl, Q24MIN, Q24MAX);
	assign lp_y = sat((tmp_q + mrsp.p) >>> 15, Q24MIN, Q24MAX);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (start) state_d = !enables[0] ? ST_DONE :
				enables[1] ? ST_PAN : enables[2] ? ST_AP_NODE :
				enables[3] ? ST_GAIN : ST_DONE;
			ST_PAN:     if (mrsp.done && last_ch)
				state_d = enables[2] ? ST_AP_NODE : enables[3] ? ST_GAIN : ST_DONE;
			ST_AP_NODE: if (mrsp.done) state_d = ST_AP_OUT;
			ST_AP_OUT:  if (mrsp.done) state_d = ST_LP_IN;
			ST_LP_IN:   if (mrsp.done) state_d = ST_LP_FB;
			ST_LP_FB:   if (mrsp.done) state_d = last_ch ? ST_CROSS : ST_AP_NODE;
			ST_CROSS:   if (mrsp.done && last_ch)
				state_d = enables[3] ? ST_GAIN : ST_DONE;
			ST_GAIN:    if (mrsp.done && last_ch) state_d = ST_DONE;
			ST_DONE:    state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mreq.start = 1'b0;
		mreq.a = '0;
		mreq.b = '0;
		if (!issued_q) begin
			case (state_q)
				ST_PAN: begin
					mreq.start = 1'b1;
					mreq.a = 40'(smp_q[1]) - 40'(smp_q[0]);
					mreq.b = 17'(pan);
				end
				ST_AP_NODE: begin
					mreq.start = 1'b1;
					mreq.a = 40'(ch_q ? dl_r_q[pos_q] : dl_l_q[pos_q]);
					mreq.b = 17'(COEF_DIRECT);
				end
				ST_AP_OUT: begin
					mreq.start = 1'b1;
					mreq.a = 40'(node_q);
					mreq.b = 17'(COEF_DIRECT);
				end
				ST_LP_IN: begin
					mreq.start = 1'b1;
					mreq.a = 40'(apo_q);
					mreq.b = 17'(COEF_LP_IN);
				end
				ST_LP_FB: begin
					mreq.start = 1'b1;
					mreq.a = 40'(lp_q[ch_q]);
					mreq.b = 17'(COEF_LP_FB);
				end
				ST_CROSS: begin
					mreq.start = 1'b1;
					mreq.a = 40'(filt_q[!ch_q]);
					mreq.b = 17'(COEF_CROSS);
				end
				ST_GAIN: begin
					mreq.start = 1'b1;
					mreq.a = 40'(smp_q[ch_q]);
					mreq.b = 17'(gain);
				end
				default: mreq.start = 1'b0;
			endcase
		end
	end

	assign own  = P'(pre_q[ch_q]) <<< 6;
	assign sum  = own + p_fl;
	assign q128 = sum < 0 ? -((-sum) >>> 7) : (sum >>> 7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ch_q     <= 1'b0;
			issued_q <= 1'b0;
			pos_q    <= '0;
			lp_q[0]  <= '0;
			lp_q[1]  <= '0;
			for (int i = 0; i < DELAY_TAPS; i++) begin
				dl_l_q[i] <= '0;
				dl_r_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (mrsp.done || state_q != state_d) issued_q <= 1'b0;
			else if (mreq.start) issued_q <= 1'b1;
			if (state_q == ST_IDLE) begin
				ch_q <= 1'b0;
			end else if (mrsp.done) begin
				case (state_q)
					ST_PAN, ST_CROSS, ST_GAIN: ch_q <= !ch_q;
					ST_AP_NODE: begin
						if (ch_q) dl_r_q[pos_q] <= STATE_W'(node_d);
						else dl_l_q[pos_q] <= STATE_W'(node_d);
					end
					ST_LP_FB: begin
						lp_q[ch_q] <= STATE_W'(lp_y);
						ch_q <= !ch_q;
						if (ch_q) pos_q <= (32'(pos_q) + 1 >= DELAY_TAPS) ? '0 : pos_q + 1'b1;
					end
					default: ch_q <= ch_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			smp_q[0] <= l_in;
			smp_q[1] <= r_in;
		end
		if (state_q == ST_AP_NODE && !issued_q)
			head_q <= ch_q ? dl_r_q[pos_q] : dl_l_q[pos_q];
		if (state_d == ST_CROSS && state_q != ST_CROSS) begin
			pre_q[0] <= smp_q[0];
			pre_q[1] <= smp_q[1];
		end
		if (mrsp.done) begin
			case (state_q)
				ST_PAN: begin
					if (ch_q) smp_q[1] <= SAMPLE_W'(sat(((P'(smp_q[1]) <<< 8) - tmp_q) >>> 8,
						S16MIN, S16MAX));
					else begin
						smp_q[0] <= SAMPLE_W'(sat(((P'(smp_q[0]) <<< 8) + mrsp.p) >>> 8,
							S16MIN, S16MAX));
						tmp_q <= mrsp.p;
					end
				end
				ST_AP_NODE: node_q <= STATE_W'(node_d);
				ST_AP_OUT: apo_q <= STATE_W'(sat(P'(head_q) + p_fl, Q24MIN, Q24MAX));
				ST_LP_IN:  tmp_q <= mrsp.p;
				ST_LP_FB:  filt_q[ch_q] <= STATE_W'(lp_y);
				ST_CROSS: smp_q[ch_q] <= SAMPLE_W'(sat(q128, S16MIN, S16MAX));
				ST_GAIN:  smp_q[ch_q] <= SAMPLE_W'(sat(mrsp.p >>> 8, S16MIN, S16MAX));
				default: tmp_q <= tmp_q;
			endcase
		end
	end

	assign busy  = state_q != ST_IDLE;
	assign done  = state_q == ST_DONE;
	assign l_res = smp_q[0];
	assign r_res = smp_q[1];
endmodule

// ===== dv/tb_stereo_pan_crossfeed_gain_chain_core.sv =====
// Testbench for the stereo pan, crossfeed and gain chain with a frame predictor.
`timescale 1ns / 1ps
module tb_stereo_pan_crossfeed_gain_chain_core;
	import spcg_pkg::*;

	localparam int TAPS = 22;

	typedef struct {
		logic [15:0] left;
		logic [15:0] right;
		logic        last;
	} frame_t;

	logic clk;
	logic arst_n;
	spcg_frame_if in_if();
	spcg_frame_if out_if();
	spcg_cfg_if   cfg_if();

	stereo_pan_crossfeed_gain_chain_core #(.DELAY_TAPS(TAPS)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_if),
		.out    (out_if),
		.cfg    (cfg_if)
	);

	// predictor state
	logic [3:0]  enables_q;
	logic [8:0]  pan_q;
	logic [15:0] gain_q;
	longint      dline[2][TAPS];
	longint      lp_val[2];
	int          ring_pos;

	frame_t expected_frames[$];
	int     failures;
	int     send_idle_pct;
	int     recv_idle_pct;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

	function automatic longint sat(longint x, longint lo, longint hi);
		return x > hi ? hi : (x < lo ? lo : x);
	endfunction

	function automatic longint allpass(int ch, int pos, longint x);
		longint head, node;
		head = dline[ch][pos];
		node = sat(x - ((longint'(COEF_DIRECT) * head) >>> 15), -8388608, 8388607);
		dline[ch][pos] = node;
		return sat(head + ((longint'(COEF_DIRECT) * node) >>> 15), -8388608, 8388607);
	endfunction

	function automatic longint lowpass(int ch, longint x);
		longint y;
		y = (longint'(COEF_LP_IN) * x + longint'(COEF_LP_FB) * lp_val[ch]) >>> 15;
		y = sat(y, -8388608, 8388607);
		lp_val[ch] = y;
		return y;
	endfunction

	function automatic longint cross_mix(longint own, longint other);
		longint s;
		s = own * 64 + ((longint'(COEF_CROSS) * other) >>> 15);
		return sat(s / 128, -32768, 32767);
	endfunction

	function automatic frame_t process_frame(logic [15:0] li, logic [15:0] ri, logic last);
		frame_t f;
		longint l, r, m, ld, rd, nl;
		int pos;
		l = longint'($signed(li));
		r = longint'($signed(ri));
		if (enables_q[0]) begin
			if (enables_q[1]) begin
				m = (r - l) * longint'(pan_q);
				nl = sat((l * 256 + m) >>> 8, -32768, 32767);
				r = sat((r * 256 - m) >>> 8, -32768, 32767);
				l = nl;
			end
			if (enables_q[2]) begin
				pos = ring_pos < TAPS ? ring_pos : 0;
				ld = allpass(0, pos, l * 64);
				rd = allpass(1, pos, r * 64);
				ring_pos = (pos + 1 >= TAPS) ? 0 : pos + 1;
				ld = lowpass(0, ld);
				rd = lowpass(1, rd);
				nl = cross_mix(l, rd);
				r = cross_mix(r, ld);
				l = nl;
			end
			if (enables_q[3]) begin
				l = sat((l * longint'(gain_q)) >>> 8, -32768, 32767);
				r = sat((r * longint'(gain_q)) >>> 8, -32768, 32767);
			end
		end
		f.left = l[15:0];
		f.right = r[15:0];
		f.last = last;
		return f;
	endfunction

	always @(posedge clk) begin
		frame_t e;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (expected_frames.size() == 0) begin
				$error("unexpected result left=%h right=%h", out_if.left, out_if.right);
				failures++;
			end else begin
				e = expected_frames.pop_front();
				if (out_if.left !== e.left) begin
					$error("left_out expected %h actual %h", e.left, out_if.left);
					failures++;
				end
				if (out_if.right !== e.right) begin
					$error("right_out expected %h actual %h", e.right, out_if.right);
					failures++;
				end
				if (out_if.last !== e.last) begin
					$error("block_last_out expected %b actual %b", e.last, out_if.last);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic wait_drained();
		in_if.valid <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		wait_drained();
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		case (idx)
			REG_ENABLES: enables_q = data[3:0];
			REG_PAN:     pan_q = data[8:0];
			REG_GAIN:    gain_q = data;
			default: ;
		endcase
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_frame(logic [15:0] l, logic [15:0] r, logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.left <= l;
		in_if.right <= r;
		in_if.last <= last;
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		expected_frames.push_back(process_frame(l, r, last));
	endtask

	task automatic end_burst();
		in_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		send_frame(16'h7fff, 16'h8000, 1'b0);
		send_frame(16'h1234, 16'hfedc, 1'b1);
		write_reg(REG_ENABLES, 16'h0000);
		send_frame(16'h8000, 16'h7fff, 1'b1);
		write_reg(REG_ENABLES, 16'h000f);
		write_reg(REG_PAN, 16'd0);
		write_reg(REG_GAIN, 16'd256);
		send_frame(16'h7fff, 16'h7fff, 1'b0);
		send_frame(16'h8000, 16'h8000, 1'b1);
		write_reg(REG_PAN, 16'd256);
		send_frame(16'h7fff, 16'h8000, 1'b0);
		send_frame(16'h0001, 16'hffff, 1'b0);
		write_reg(REG_PAN, 16'hffff);
		send_frame(16'h7fff, 16'h8000, 1'b1);
		send_frame(16'h8000, 16'h7fff, 1'b0);
		write_reg(REG_GAIN, 16'd0);
		send_frame(16'h7fff, 16'h8000, 1'b0);
		write_reg(REG_GAIN, 16'd32768);
		send_frame(16'h4000, 16'hc000, 1'b1);
		write_reg(REG_GAIN, 16'hffff);
		send_frame(16'h0100, 16'hff00, 1'b0);
		write_reg(2'd3, 16'hffff);
		send_frame(16'h7fff, 16'h8000, 1'b1);
		write_reg(REG_ENABLES, 16'h0005);
		for (int i = 0; i < 6; i++)
			send_frame(16'h7fff, 16'h8000, i[0]);
		write_reg(REG_ENABLES, 16'h000e);
		send_frame(16'h5555, 16'haaaa, 1'b0);
		end_burst();
	endtask

	task automatic test_random(int bursts, int per_burst);
		for (int b = 0; b < bursts; b++) begin
			write_reg(REG_ENABLES, ($urandom_range(3) == 0) ? 16'($urandom) : 16'h000f);
			case ($urandom_range(3))
				0: write_reg(REG_PAN, 16'd0);
				1: write_reg(REG_PAN, 16'd256);
				2: write_reg(REG_PAN, 16'h01ff);
				default: write_reg(REG_PAN, 16'($urandom));
			endcase
			case ($urandom_range(3))
				0: write_reg(REG_GAIN, 16'd256);
				1: write_reg(REG_GAIN, 16'd32768);
				2: write_reg(REG_GAIN, 16'd0);
				default: write_reg(REG_GAIN, 16'($urandom));
			endcase
			for (int i = 0; i < per_burst; i++) begin
				if (i == per_burst / 2 && b == 0) begin
					end_burst();
					wait_drained();
				end
				send_frame(rand_sample(), rand_sample(), 1'($urandom));
			end
			end_burst();
		end
	endtask

	initial begin
		failures = 0;
		send_idle_pct = 15;
		recv_idle_pct = 64;
		enables_q = 4'd1;
		pan_q = 9'd89;
		gain_q = 16'd256;
		ring_pos = 0;
		for (int c = 0; c < 2; c++) begin
			lp_val[c] = 0;
			for (int t = 0; t < TAPS; t++)
				dline[c][t] = 0;
		end
		arst_n <= 1'b0;
		in_if.valid <= 1'b0;
		in_if.left <= '0;
		in_if.right <= '0;
		in_if.last <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= '0;
		cfg_if.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(6, 100);
		send_idle_pct = 64;
		recv_idle_pct = 15;
		test_random(6, 100);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(6, 105);

		wait_drained();
		repeat (300) @(posedge clk);
		if (failures == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/spcg_pkg.sv
rtl/spcg_if.sv
rtl/spcg_serial_mul.sv
rtl/spcg_seq.sv
rtl/stereo_pan_crossfeed_gain_chain_core.sv
dv/tb_stereo_pan_crossfeed_gain_chain_core.sv
